// ===== hw/rtl/b3lif_pkg.sv =====
// package for the binary 3x3 lookup-table image filter
// widths, codes, step and result types, and the table bit select shared by all modules
// no dependencies
package b3lif_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int ADDR_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int COL_W       = $clog2(MAX_WIDTH + 2);
    localparam int LUT_WORDS   = 8;
    localparam int LUT_WORD_W  = 64;
    localparam int IDX_W       = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int FIFO_DEPTH  = 3;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [IDX_W-1:0] IDX_ALL_CLEAR = '0;
    localparam logic [IDX_W-1:0] IDX_ALL_SET   = '1;

    typedef enum logic [1:0] {
        SRC_BG     = 2'd0,
        SRC_UPPER  = 2'd1,
        SRC_MIDDLE = 2'd2
    } src_t;

    typedef logic [LUT_WORDS-1:0][LUT_WORD_W-1:0] lut_t;

    // one window column step: shift in a column, look up, emit one item
    typedef struct packed {
        logic              valid;
        logic              win_clear;
        logic              bg;
        src_t              top_src;
        src_t              mid_src;
        logic              bot_bit;
        logic              row_end;
        logic              frame_end;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_pix;
    } step_t;

    typedef struct packed {
        logic pixel;
        logic row_end;
        logic frame_end;
    } res_t;

    function automatic logic lut_bit(lut_t lut, logic [IDX_W-1:0] idx);
        lut_bit = lut[idx[8:6]][idx[5:0]];
    endfunction

endpackage

// ===== hw/rtl/b3lif_line_buf.sv =====
// two line buffers holding the two input rows above the current one
// one read address and one write address per cycle, read data registered
// depends on b3lif_pkg
module b3lif_line_buf
    import b3lif_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_upper,
    input  logic              wr_middle,
    output logic              upper_rd,
    output logic              middle_rd
);

    logic upper_mem  [MAX_WIDTH];
    logic middle_mem [MAX_WIDTH];
    logic upper_rd_reg;
    logic middle_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_rd_reg  <= upper_mem[rd_addr];
            middle_rd_reg <= middle_mem[rd_addr];
        end
    end

    assign upper_rd  = upper_rd_reg;
    assign middle_rd = middle_rd_reg;

endmodule

// ===== hw/rtl/b3lif_seq.sv =====
// item sequencer: turns pixel and drain items into window column steps
// tracks columns, rows, row width, drain position and the background bit
// depends on b3lif_pkg
module b3lif_seq
    import b3lif_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic                  pixel_in,
    input  logic                  row_end_in,
    input  logic                  frame_end_in,
    input  lut_t                  lut,
    input  logic [FIFO_CNT_W-1:0] fifo_count,
    input  logic                  b_busy,
    output step_t                 step,
    output logic                  rd_en,
    output logic [ADDR_W-1:0]     rd_addr
);

    logic [ADDR_W-1:0] col_reg,        col_next;
    logic [COL_W-1:0]  row_width_reg,  row_width_next;
    logic [1:0]        rows_seen_reg,  rows_seen_next;
    logic              bg_reg,         bg_next;
    logic              drain_active_reg, drain_active_next;
    logic              drain_row_reg,  drain_row_next;
    logic [COL_W-1:0]  drain_col_reg,  drain_col_next;
    logic [1:0]        pend_reg,       pend_next;

    logic                space_ok;
    logic                accept;
    logic [FIFO_CNT_W:0] in_flight;
    logic                row_done;
    logic                in_range;
    logic                drain_row_end;
    src_t                upper_src;
    src_t                middle_src;

    assign in_flight = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, b_busy};
    assign space_ok  = in_flight < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign in_ready  = space_ok && (pend_reg == 2'd0);
    assign accept    = in_valid && in_ready;

    assign row_done      = row_end_in || frame_end_in || (col_reg == ADDR_W'(MAX_WIDTH - 1));
    assign in_range      = drain_col_reg < row_width_reg;
    assign drain_row_end = drain_col_reg == (row_width_reg + COL_W'(1));
    assign upper_src     = (rows_seen_reg >= 2'd2) ? SRC_UPPER : SRC_BG;
    assign middle_src    = (rows_seen_reg >= 2'd1) ? SRC_MIDDLE : SRC_BG;

    always_comb
    begin
        col_next          = col_reg;
        row_width_next    = row_width_reg;
        rows_seen_next    = rows_seen_reg;
        bg_next           = bg_reg;
        drain_active_next = drain_active_reg;
        drain_row_next    = drain_row_reg;
        drain_col_next    = drain_col_reg;
        pend_next         = pend_reg;
        step              = '0;
        step.bg           = bg_reg;
        step.bot_bit      = bg_reg;
        step.top_src      = SRC_BG;
        step.mid_src      = SRC_BG;
        rd_en             = 1'b0;
        rd_addr           = col_reg;

        if (pend_reg != 2'd0)
        begin
            // border columns right of a finished row
            if (space_ok)
            begin
                step.valid   = 1'b1;
                step.row_end = (pend_reg == 2'd1);
                pend_next    = pend_reg - 2'd1;
            end
        end
        else if (accept)
        begin
            unique case (action)
                ACT_PIXEL:
                begin
                    if (!drain_active_reg)
                    begin
                        step.valid     = 1'b1;
                        step.win_clear = (col_reg == '0);
                        step.top_src   = upper_src;
                        step.mid_src   = middle_src;
                        step.bot_bit   = pixel_in;
                        step.wr_en     = 1'b1;
                        step.wr_addr   = col_reg;
                        step.wr_pix    = pixel_in;
                        rd_en          = 1'b1;
                        rd_addr        = col_reg;
                        if (row_done)
                        begin
                            pend_next      = 2'd2;
                            row_width_next = COL_W'(col_reg) + COL_W'(1);
                            col_next       = '0;
                            rows_seen_next = (rows_seen_reg == 2'd2) ? 2'd2
                                                                     : rows_seen_reg + 2'd1;
                            if (frame_end_in)
                            begin
                                drain_active_next = 1'b1;
                                drain_row_next    = 1'b0;
                                drain_col_next    = '0;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + ADDR_W'(1);
                        end
                    end
                end
                ACT_DRAIN:
                begin
                    if (drain_active_reg)
                    begin
                        step.valid     = 1'b1;
                        step.win_clear = (drain_col_reg == '0);
                        step.row_end   = drain_row_end;
                        step.frame_end = drain_row_end && drain_row_reg;
                        rd_en          = in_range;
                        rd_addr        = drain_col_reg[ADDR_W-1:0];
                        if (in_range)
                        begin
                            if (drain_row_reg)
                            begin
                                step.top_src = (rows_seen_reg >= 2'd1) ? SRC_MIDDLE : SRC_BG;
                            end
                            else
                            begin
                                step.top_src = upper_src;
                                step.mid_src = middle_src;
                            end
                        end
                        if (drain_row_end)
                        begin
                            drain_col_next = '0;
                            drain_row_next = 1'b1;
                        end
                        else
                        begin
                            drain_col_next = drain_col_reg + COL_W'(1);
                        end
                        if (drain_row_end && drain_row_reg)
                        begin
                            drain_active_next = 1'b0;
                            bg_next           = bg_reg ? lut_bit(lut, IDX_ALL_SET)
                                                       : lut_bit(lut, IDX_ALL_CLEAR);
                            rows_seen_next    = 2'd0;
                            col_next          = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_width_reg    <= '0;
            rows_seen_reg    <= 2'd0;
            bg_reg           <= 1'b0;
            drain_active_reg <= 1'b0;
            drain_row_reg    <= 1'b0;
            drain_col_reg    <= '0;
            pend_reg         <= 2'd0;
        end
        else
        begin
            col_reg          <= col_next;
            row_width_reg    <= row_width_next;
            rows_seen_reg    <= rows_seen_next;
            bg_reg           <= bg_next;
            drain_active_reg <= drain_active_next;
            drain_row_reg    <= drain_row_next;
            drain_col_reg    <= drain_col_next;
            pend_reg         <= pend_next;
        end
    end

    // a frame-ending pixel owes two border columns and arms the drain
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == ACT_PIXEL) && !drain_active_reg && frame_end_in
        |=> drain_active_reg && (pend_reg == 2'd2))
        else $error("frame end did not arm the drain");

    assert property (@(posedge clk) disable iff (!rst_n)
        drain_active_reg |-> drain_col_reg <= (row_width_reg + COL_W'(1)))
        else $error("drain column past the border");

endmodule

// ===== hw/rtl/b3lif_window.sv =====
// 3x3 window stage: shifts in one column per step and looks up the table
// also writes back the line buffers for pixel steps
// depends on b3lif_pkg
module b3lif_window
    import b3lif_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  step_t             step_in,
    input  lut_t              lut,
    input  logic              upper_rd,
    input  logic              middle_rd,
    output logic              b_busy,
    output logic              push,
    output res_t              res,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic              wr_upper,
    output logic              wr_middle
);

    step_t            step_reg;
    logic [IDX_W-1:0] window_reg;
    logic [IDX_W-1:0] window_next;
    logic [IDX_W-1:0] base;
    logic             top_bit;
    logic             mid_bit;

    always_comb
    begin
        unique case (step_reg.top_src)
            SRC_UPPER:  top_bit = upper_rd;
            SRC_MIDDLE: top_bit = middle_rd;
            SRC_BG:     top_bit = step_reg.bg;
            default:    top_bit = step_reg.bg;
        endcase
        mid_bit     = (step_reg.mid_src == SRC_MIDDLE) ? middle_rd : step_reg.bg;
        base        = step_reg.win_clear ? {IDX_W{step_reg.bg}} : window_reg;
        window_next = {base[7:6], top_bit, base[4:3], mid_bit, base[1:0], step_reg.bot_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            window_reg <= '0;
        end
        else
        begin
            step_reg <= step_in;
            if (step_reg.valid)
            begin
                window_reg <= window_next;
            end
        end
    end

    assign b_busy        = step_reg.valid;
    assign push          = step_reg.valid;
    assign res.pixel     = lut_bit(lut, window_next);
    assign res.row_end   = step_reg.row_end;
    assign res.frame_end = step_reg.frame_end;
    assign wr_en         = step_reg.valid && step_reg.wr_en;
    assign wr_addr       = step_reg.wr_addr;
    assign wr_upper      = middle_rd;
    assign wr_middle     = step_reg.wr_pix;

    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg.valid && step_reg.frame_end |-> step_reg.row_end)
        else $error("frame end item does not close a row");

endmodule

// ===== hw/rtl/b3lif_out_fifo.sv =====
// three-entry result queue between the window stage and the output port
// fill count gives a registered ready: one item per cycle while out_ready is high
// depends on b3lif_pkg
module b3lif_out_fifo
    import b3lif_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  res_t                  push_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output res_t                  head,
    output logic [FIFO_CNT_W-1:0] count
);

    res_t                  fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg,  count_next;
    logic                  pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign head      = fifo_mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

endmodule

// ===== hw/rtl/binary_3x3_lut_image_filter.sv =====
// top level of the binary 3x3 lookup-table image filter
// holds the table registers and joins sequencer, line buffers, window stage and result queue
// depends on b3lif_pkg and the b3lif_* modules
//
// Takes a raster stream of binary pixels (action = 0) with row and frame end marks and
// emits the filtered frame grown by one pixel on every side; each output pixel is the
// table entry picked by its 3x3 neighborhood, top-left as index bit 8, with pixels outside
// the frame reading as the background bit. After the frame end pixel, send 2*(W+2) drain
// items (action = 1) to flush the last two output rows; the final one carries frame_end_out
// and updates the background from table entry 511 or 0. Pixels sent while a drain is owed,
// and drains sent when none is owed, are taken and dropped. One item is taken per clock
// while the result queue has room; a row-ending pixel also holds off input for its two
// border columns, as the single window and lookup stage produces one result per clock.
// An item's first result passes the window stage register and the result queue before
// it is offered. Rows are at most 128 pixels; a longer row is cut there.
// Table registers 0 to 7 hold entries 64*i to 64*i+63; the user must write them only while idle (not enforced).
module binary_3x3_lut_image_filter
    import b3lif_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic                  pixel_in,
    input  logic                  row_end_in,
    input  logic                  frame_end_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  pixel_out,
    output logic                  row_end_out,
    output logic                  frame_end_out
);

    lut_t                  lut_reg;
    step_t                 step;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  upper_rd;
    logic                  middle_rd;
    logic                  b_busy;
    logic                  push;
    res_t                  res;
    res_t                  head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  wr_upper;
    logic                  wr_middle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lut_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            lut_reg[cfg_index] <= cfg_data;
        end
    end

    b3lif_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .pixel_in     (pixel_in),
        .row_end_in   (row_end_in),
        .frame_end_in (frame_end_in),
        .lut          (lut_reg),
        .fifo_count   (fifo_count),
        .b_busy       (b_busy),
        .step         (step),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr)
    );

    b3lif_line_buf u_line_buf (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_upper  (wr_upper),
        .wr_middle (wr_middle),
        .upper_rd  (upper_rd),
        .middle_rd (middle_rd)
    );

    b3lif_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_in   (step),
        .lut       (lut_reg),
        .upper_rd  (upper_rd),
        .middle_rd (middle_rd),
        .b_busy    (b_busy),
        .push      (push),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_upper  (wr_upper),
        .wr_middle (wr_middle)
    );

    b3lif_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .count     (fifo_count)
    );

    assign pixel_out     = head.pixel;
    assign row_end_out   = head.row_end;
    assign frame_end_out = head.frame_end;

endmodule
